[sv/clnc_pkg.sv]
// Shared types, constants and the wake-up write table of the character LCD controller.
`timescale 1ns / 1ps

package clnc_pkg;

    // Geometry of the display
    localparam int MAX_COLUMNS   = 40;
    localparam int FOUR_ROW_WRAP = 20;
    localparam int COL_W         = 6;
    localparam int ROW_W         = 2;

    // Job queue between front and back
    localparam int JOB_DEPTH = 2;
    localparam int PTR_W     = $clog2(JOB_DEPTH);
    localparam int CNT_W     = $clog2(JOB_DEPTH + 1);

    // Wake-up sequence: nine writes, sent twice
    localparam int             INIT_LEN   = 9;
    localparam int             STEP_W     = 5;
    localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(2 * INIT_LEN - 1);

    // Action codes
    localparam logic [1:0] ACT_INIT = 2'd0;
    localparam logic [1:0] ACT_CHAR = 2'd1;
    localparam logic [1:0] ACT_GOTO = 2'd2;

    // Job kinds
    localparam logic [1:0] KIND_INIT = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_WRAP = 2'd2;
    localparam logic [1:0] KIND_CMD  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;

    // Reset values of the configuration registers
    localparam logic [2:0] ROWS_RESET = 3'd2;
    localparam logic [5:0] COLS_RESET = 6'd16;

    // Command bytes
    localparam logic [7:0] DDRAM_SET   = 8'h80;
    localparam logic [7:0] ROW1_OFFSET = 8'h40;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [6:0] addr;
    } t_job;

    typedef struct packed {
        logic       register_select;
        logic [7:0] write_value;
        logic       nibble_only;
        logic       wait_busy;
        logic [6:0] delay_before_ms;
        logic [2:0] delay_after_ms;
        logic       last;
    } t_write;

    // One write of the wake-up sequence; last is filled in by the caller
    function automatic t_write init_write(input logic [3:0] idx);
        t_write w;
        w = '0;
        case (idx)
            4'd0: begin
                w.write_value = 8'h03; w.nibble_only = 1'b1; w.delay_before_ms = 7'd100;
            end
            4'd1: begin
                w.write_value = 8'h03; w.nibble_only = 1'b1; w.delay_before_ms = 7'd5;
            end
            4'd2: begin
                w.write_value = 8'h03; w.nibble_only = 1'b1; w.delay_before_ms = 7'd1;
            end
            4'd3: begin
                w.write_value = 8'h02; w.nibble_only = 1'b1; w.delay_before_ms = 7'd1;
            end
            4'd4: begin
                w.write_value = 8'h28; w.delay_before_ms = 7'd1;
            end
            4'd5: begin
                w.write_value = 8'h08; w.wait_busy = 1'b1;
            end
            4'd6: begin
                w.write_value = 8'h01; w.wait_busy = 1'b1; w.delay_after_ms = 3'd3;
            end
            4'd7: begin
                w.write_value = 8'h06; w.wait_busy = 1'b1;
            end
            4'd8: begin
                w.write_value = 8'h0F; w.wait_busy = 1'b1;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

[sv/char_lcd_nibble_controller.sv]
// Character LCD 4-bit controller: action queue in, bus write queue out.
// The first write of an action goes through the job queue and the output register.
// Throughput: one write per cycle from the sequencer unless stalled; initialize gives 18
// writes, a character 1 (2 on a cursor wrap), go to position 1; code 3 yields nothing.
// The sequencer walks the head job of a two-entry queue, so short actions flow back to back.
// Reset (synchronous, active low): cursor to 0,0, rows 2, columns 16, queues empty.
`timescale 1ns / 1ps

module char_lcd_nibble_controller import clnc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_char_code,
    input  logic [COL_W-1:0] i_column,
    input  logic [ROW_W-1:0] i_row,
    output logic             empty,
    input  logic             pop,
    output logic             o_register_select,
    output logic [7:0]       o_write_value,
    output logic             o_nibble_only,
    output logic             o_wait_busy,
    output logic [6:0]       o_delay_before_ms,
    output logic [2:0]       o_delay_after_ms,
    output logic             o_last,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

    logic   accept;
    logic   job_push;
    t_job   job_in;
    t_job   job_head;
    logic   job_valid;
    logic   job_pop;
    logic   out_valid;
    t_write out_write;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;

    // Classify actions and track the cursor
    clnc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_char_code (i_char_code),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    // Buffer jobs between front and back
    clnc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_push),
        .i_data  (job_in),
        .i_rd    (job_pop),
        .o_data  (job_head),
        .o_valid (job_valid),
        .o_full  (full)
    );

    // Expand jobs into bus writes
    clnc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_head),
        .i_job_valid (job_valid),
        .i_pop       (pop),
        .o_job_pop   (job_pop),
        .o_valid     (out_valid),
        .o_write     (out_write)
    );

    // Drive the result ports
    assign empty             = !out_valid;
    assign o_register_select = out_write.register_select;
    assign o_write_value     = out_write.write_value;
    assign o_nibble_only     = out_write.nibble_only;
    assign o_wait_busy       = out_write.wait_busy;
    assign o_delay_before_ms = out_write.delay_before_ms;
    assign o_delay_after_ms  = out_write.delay_after_ms;
    assign o_last            = out_write.last;

endmodule

[sv/clnc_front.sv]
// Front end: holds configuration and cursor, turns each action into a job.
`timescale 1ns / 1ps

module clnc_front import clnc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_char_code,
    input  logic [COL_W-1:0] i_column,
    input  logic [ROW_W-1:0] i_row,
    input  logic             i_cfg_wr,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    output logic             o_job_push,
    output t_job             o_job
);

    logic [2:0]       r_rows;
    logic [5:0]       r_cols;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [COL_W:0]   c_inc;
    logic             wrap;
    logic [ROW_W-1:0] wrap_row;
    logic [COL_W-1:0] char_col;
    logic [ROW_W-1:0] char_row;

    // DDRAM address for a column and row under the current layout
    function automatic logic [6:0] ddram_addr(input logic [COL_W-1:0] col,
                                              input logic [ROW_W-1:0] row,
                                              input logic [2:0] rows,
                                              input logic [5:0] cols);
        logic [7:0] a;
        a = {2'b00, col};
        if (rows == 3'd2) begin
            if (row != 2'd0) a = a + ROW1_OFFSET;
        end else if (rows == 3'd4) begin
            case (row)
                2'd1:    a = a + ROW1_OFFSET;
                2'd2:    a = a + {2'b00, cols};
                2'd3:    a = a + ROW1_OFFSET + {2'b00, cols};
                default: a = a;
            endcase
        end
        return a[6:0];
    endfunction

    // Advance the cursor for a character and detect a wrap
    always_comb begin
        c_inc    = {1'b0, r_col} + (COL_W+1)'(1);
        wrap     = 1'b0;
        wrap_row = r_row;
        if (r_rows == 3'd4) begin
            wrap     = c_inc >= (COL_W+1)'(FOUR_ROW_WRAP);
            wrap_row = r_row + 2'd1;
        end else if (r_rows == 3'd2) begin
            wrap     = c_inc >= (COL_W+1)'(MAX_COLUMNS);
            wrap_row = (r_row >= 2'd1) ? 2'd0 : r_row + 2'd1;
        end else begin
            wrap     = c_inc >= (COL_W+1)'(MAX_COLUMNS);
            wrap_row = r_row;
        end
        char_col = wrap ? '0 : c_inc[COL_W-1:0];
        char_row = wrap ? wrap_row : r_row;
    end

    // Classify the action into a job and the next cursor
    always_comb begin
        o_job      = '0;
        o_job_push = 1'b0;
        n_col      = r_col;
        n_row      = r_row;
        case (i_action)
            ACT_INIT: begin
                o_job.kind = KIND_INIT;
                o_job_push = i_accept;
                n_col      = '0;
                n_row      = '0;
            end
            ACT_CHAR: begin
                o_job.kind      = wrap ? KIND_WRAP : KIND_DATA;
                o_job.char_code = i_char_code;
                o_job.addr      = ddram_addr(char_col, char_row, r_rows, r_cols);
                o_job_push      = i_accept;
                n_col           = char_col;
                n_row           = char_row;
            end
            ACT_GOTO: begin
                o_job.kind = KIND_CMD;
                o_job.addr = ddram_addr(i_column, i_row, r_rows, r_cols);
                o_job_push = i_accept;
                n_col      = i_column;
                n_row      = i_row;
            end
            default: begin
                o_job_push = 1'b0;
            end
        endcase
    end

    // Hold cursor, update on each accepted action
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_ROWS: r_rows <= i_cfg_data[2:0];
                CFG_COLS: r_cols <= i_cfg_data[5:0];
                default:  r_rows <= r_rows;
            endcase
        end
    end

endmodule

[sv/clnc_queue.sv]
// Short job queue that decouples the front end from the write sequencer.
`timescale 1ns / 1ps

module clnc_queue import clnc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_data,
    input  logic i_rd,
    output t_job o_data,
    output logic o_valid,
    output logic o_full
);

    t_job             r_mem [JOB_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = r_count == CNT_W'(JOB_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) r_wp <= (r_wp == PTR_W'(JOB_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            if (do_rd) r_rp <= (r_rp == PTR_W'(JOB_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            if (do_wr && !do_rd)      r_count <= r_count + CNT_W'(1);
            else if (do_rd && !do_wr) r_count <= r_count - CNT_W'(1);
        end
    end

    // Store the job
    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wp] <= i_data;
    end

endmodule

[sv/clnc_back.sv]
// Back end: expands the head job into registered writes, one per cycle unless stalled.
`timescale 1ns / 1ps

module clnc_back import clnc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_job   i_job,
    input  logic   i_job_valid,
    input  logic   i_pop,
    output logic   o_job_pop,
    output logic   o_valid,
    output t_write o_write
);

    logic              r_valid;
    logic [STEP_W-1:0] r_step;
    t_write            r_out;
    logic              advance;
    logic              load;
    logic              final_step;
    logic [3:0]        init_idx;
    t_write            w;

    assign advance   = !r_valid || i_pop;
    assign load      = advance && i_job_valid;
    assign o_job_pop = load && final_step;
    assign o_valid   = r_valid;
    assign o_write   = r_out;

    // Pick the write for the current step of the head job
    always_comb begin
        init_idx   = (r_step >= STEP_W'(INIT_LEN)) ? 4'(r_step - STEP_W'(INIT_LEN))
                                                  : r_step[3:0];
        w          = '0;
        final_step = 1'b1;
        case (i_job.kind)
            KIND_INIT: begin
                w          = init_write(init_idx);
                final_step = r_step == INIT_LAST;
            end
            KIND_DATA: begin
                w.register_select = 1'b1;
                w.write_value     = i_job.char_code;
                w.wait_busy       = 1'b1;
                w.delay_after_ms  = 3'd2;
            end
            KIND_WRAP: begin
                final_step  = r_step == STEP_W'(1);
                w.wait_busy = 1'b1;
                if (final_step) begin
                    w.write_value    = DDRAM_SET | {1'b0, i_job.addr};
                    w.delay_after_ms = 3'd4;
                end else begin
                    w.register_select = 1'b1;
                    w.write_value     = i_job.char_code;
                end
            end
            KIND_CMD: begin
                w.write_value    = DDRAM_SET | {1'b0, i_job.addr};
                w.wait_busy      = 1'b1;
                w.delay_after_ms = 3'd2;
            end
            default: begin
                w = '0;
            end
        endcase
        w.last = final_step;
    end

    // Advance step and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (advance) begin
            r_valid <= i_job_valid;
            if (load) r_step <= final_step ? '0 : r_step + STEP_W'(1);
        end
    end

    // Load the output write
    always_ff @(posedge i_clk) begin
        if (load) r_out <= w;
    end

`ifndef SYNTHESIS
    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && final_step |=> r_out.last)
        else $error("final write of a job lacks last");
    a_no_early_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && !final_step |=> !r_out.last)
        else $error("last set before the final write of a job");
    a_step_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && final_step |=> r_step == '0)
        else $error("step counter not restarted after a job");
    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> i_job_valid)
        else $error("job popped from an empty queue");
`endif

endmodule
